[rtl/core/best_fit_free_block_store_macros.svh]
// Assertion macros shared by the best-fit free block store RTL.
`ifndef BEST_FIT_FREE_BLOCK_STORE_MACROS_SVH
`define BEST_FIT_FREE_BLOCK_STORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BFBS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define BFBS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bfbs_pkg.sv]
// Types and constants of the best-fit free block store.
package bfbs_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam logic [15:0] MIN_SIZE_RESET = 16'd16;

    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_GRANTED = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BELOW   = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [47:0] block_address;
        logic [31:0] block_size;
    } bfbs_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] granted_address;
        logic [31:0] granted_size;
        logic [39:0] free_total;
    } bfbs_out_t;

    typedef struct packed {
        logic [31:0] size;
        logic [47:0] address;
    } bfbs_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT_RD,
        S_PUT_CHK,
        S_INS,
        S_TAKE_RD,
        S_TAKE_CHK,
        S_DONE
    } bfbs_state_t;

endpackage

[rtl/core/bfbs_table.sv]
// Size-sorted entry table: one write port, one read port with registered data.
module bfbs_table
    import bfbs_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  bfbs_entry_t                wr_data,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output bfbs_entry_t                rd_data
);

    bfbs_entry_t mem [ENTRIES];
    bfbs_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/best_fit_free_block_store.sv]
// Best-fit free block store: keeps up to ENTRIES free blocks sorted by size in a table with one
// write port and one read port and serves put and take requests one at a time through a small
// sequencer with one shared entry size comparator. A take is granted the smallest block at least
// as large as asked for (the newest among equal sizes); a put inserts in order. A request below
// the minimum size, a put into a full store or a take from an empty store goes straight to the
// reply without visiting the table; a put moves each larger-or-equal entry up one slot, walking
// down from the top, and a take visits every stored entry. Each table entry visited is first
// read through the registered read port, then compared and moved. The reply becomes valid in
// the same cycle that the next request can be taken; a reply still held by out_stall keeps the
// next one, and the block, waiting.
// There is no clearing pass after reset; the first request can follow at once.
// Configuration writes are always taken (cfg_ready is high).
`include "best_fit_free_block_store_macros.svh"

module best_fit_free_block_store
    import bfbs_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  bfbs_in_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output bfbs_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    bfbs_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [39:0] total_reg, total_next;
    logic [15:0] min_reg;
    bfbs_in_t req_reg, req_next;
    logic found_reg, found_next;
    bfbs_entry_t grant_reg, grant_next;
    bfbs_out_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    bfbs_out_t out_data_reg, out_data_next;

    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    bfbs_entry_t wr_data;
    bfbs_entry_t rd_data;
    bfbs_entry_t new_entry;
    bfbs_entry_t take_entry;
    logic fits;
    logic out_free;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] last_idx;
    logic [39:0] put_total;
    logic [39:0] take_total;

    bfbs_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared size comparator
    assign fits       = (rd_data.size >= req_reg.block_size);
    assign new_entry  = '{size: req_reg.block_size, address: req_reg.block_address};
    assign take_entry = found_reg ? grant_reg : rd_data;
    assign idx_inc    = idx_reg + CW'(1);
    assign idx_dec    = idx_reg - CW'(1);
    assign last_idx   = count_reg - CW'(1);
    assign put_total  = total_reg + 40'(req_reg.block_size);
    assign take_total = total_reg - 40'(take_entry.size);
    assign out_free   = !out_valid_reg || !out_stall;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            min_reg       <= MIN_SIZE_RESET;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            if (cfg_valid)
            begin
                min_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        grant_reg    <= grant_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        req_next       = req_reg;
        found_next     = found_reg;
        grant_next     = grant_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_data        = new_entry;
        rd_addr        = idx_reg[AW-1:0];
        in_stall       = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next            = in_data;
                    found_next          = 1'b0;
                    grant_next          = '0;
                    res_next            = '0;
                    res_next.free_total = total_reg;
                    if (in_data.block_size < {16'd0, min_reg})
                    begin
                        res_next.status = ST_BELOW;
                        state_next      = S_DONE;
                    end
                    else if (in_data.mode == MODE_PUT)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            idx_next   = '0;
                            state_next = S_INS;
                        end
                        else
                        begin
                            // walk down from the top, shifting larger-or-equal entries up
                            idx_next   = last_idx;
                            state_next = S_PUT_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_NOFIT;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_TAKE_RD;
                        end
                    end
                end
            end

            S_PUT_RD:
            begin
                state_next = S_PUT_CHK;
            end

            S_PUT_CHK:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_inc[AW-1:0];
                if (fits)
                begin
                    wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        idx_next   = idx_dec;
                        state_next = S_PUT_RD;
                    end
                end
                else
                begin
                    wr_data             = new_entry;
                    count_next          = count_reg + CW'(1);
                    total_next          = put_total;
                    res_next.status     = ST_STORED;
                    res_next.free_total = put_total;
                    state_next          = S_DONE;
                end
            end

            S_INS:
            begin
                wr_en               = 1'b1;
                wr_addr             = idx_reg[AW-1:0];
                wr_data             = new_entry;
                count_next          = count_reg + CW'(1);
                total_next          = put_total;
                res_next.status     = ST_STORED;
                res_next.free_total = put_total;
                state_next          = S_DONE;
            end

            S_TAKE_RD:
            begin
                state_next = S_TAKE_CHK;
            end

            S_TAKE_CHK:
            begin
                // after the hit, every later entry moves down one slot
                if (found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_dec[AW-1:0];
                    wr_data = rd_data;
                end
                else if (fits)
                begin
                    found_next = 1'b1;
                    grant_next = rd_data;
                end

                if (idx_reg == last_idx)
                begin
                    if (found_reg || fits)
                    begin
                        count_next               = last_idx;
                        total_next               = take_total;
                        res_next.status          = ST_GRANTED;
                        res_next.granted_address = take_entry.address;
                        res_next.granted_size    = take_entry.size;
                        res_next.free_total      = take_total;
                    end
                    else
                    begin
                        res_next.status     = ST_NOFIT;
                        res_next.free_total = total_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_TAKE_RD;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BFBS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FULL_COUNT, "entry count over capacity")
    `BFBS_ASSERT_NXT(a_put_count, (state_reg == S_INS) || (state_reg == S_PUT_CHK && !fits), count_reg == $past(count_reg) + CW'(1), "stored put did not bump count")
    `BFBS_ASSERT_IMP(a_no_grant_zero, out_valid_reg && out_data_reg.status != ST_GRANTED, out_data_reg.granted_address == '0 && out_data_reg.granted_size == '0, "non-grant result carries a block")

endmodule
